[hdl/ckx_pkg.sv]
package ckx_pkg;

    localparam int WORD_W  = 62;
    localparam int FLANK_W = 3;
    localparam int POS_W   = 12;
    localparam int COUNT_W = 13;
    localparam int KLEN_W  = 5;
    localparam int SHAMT_W = 6;

    localparam logic [KLEN_W-1:0]  MAX_K      = 5'd31;
    localparam logic [KLEN_W-1:0]  KLEN_RESET = 5'd31;
    localparam logic [FLANK_W-1:0] NONE_BASE  = 3'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'h1FFF;

    typedef struct packed {
        logic [WORD_W-1:0]  fwd;
        logic [WORD_W-1:0]  rc;
        logic [FLANK_W-1:0] prev;
        logic [FLANK_W-1:0] next;
        logic [POS_W-1:0]   pos;
        logic               last;
    } t_kreq;

    typedef struct packed {
        logic  valid0;
        logic  valid1;
        t_kreq req0;
        t_kreq req1;
    } t_qwr;

endpackage

[hdl/canonical_kmer_extractor_top.sv]
// canonical k-mer extractor
// input: one 2-bit base per request on i_base, i_last_base marks the final base
// of a read; a request is taken at a clock edge with push high and full low.
// results: one canonical k-mer per request, oldest on the o_ ports while empty
// is low, taken at a clock edge with pop high and empty low.
// each k-mer leaves when the base after it arrives; at the last base of a read
// the final k-mer follows too, so one base can give two results.
// kmer_len is written through i_cfg_we / i_cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce this.
// throughput: one base per cycle while full is low; results leave one per cycle
// while pop is high. the queue is written at the edge that takes a base; the
// canonical compare then loads the output register once it is free or popped.
// a request queue of QUEUE_DEPTH entries sits between the rolling front and
// the compare stage; full rises when fewer than two entries are free.
// while pop is held low the output register and queue hold their contents and
// full eventually stops further bases; nothing is lost.
// synchronous reset clears the read state, empties the queue and sets
// kmer_len to 31; no clearing pass is needed.
module canonical_kmer_extractor_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_base,
    input  logic                        i_last_base,
    input  logic                        pop,
    output logic                        empty,
    output logic [ckx_pkg::WORD_W-1:0]  o_canonical_kmer,
    output logic [ckx_pkg::FLANK_W-1:0] o_prev_base,
    output logic [ckx_pkg::FLANK_W-1:0] o_next_base,
    output logic                        o_from_reverse,
    output logic [ckx_pkg::POS_W-1:0]   o_kmer_pos,
    output logic                        o_last_kmer,
    input  logic                        i_cfg_we,
    input  logic [ckx_pkg::KLEN_W-1:0]  i_cfg_wdata
);

    ckx_pkg::t_qwr  wr;
    ckx_pkg::t_kreq head;
    logic           q_empty;
    logic           take;

    ckx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_base      (i_base),
        .i_last_base (i_last_base),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_wr        (wr)
    );

    ckx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pop   (take),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    ckx_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_head_valid     (!q_empty),
        .i_pop            (pop),
        .o_take           (take),
        .o_empty          (empty),
        .o_canonical_kmer (o_canonical_kmer),
        .o_prev_base      (o_prev_base),
        .o_next_base      (o_next_base),
        .o_from_reverse   (o_from_reverse),
        .o_kmer_pos       (o_kmer_pos),
        .o_last_kmer      (o_last_kmer)
    );

endmodule

[hdl/ckx_front.sv]
module ckx_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic [1:0]                    i_base,
    input  logic                          i_last_base,
    input  logic                          i_cfg_we,
    input  logic [ckx_pkg::KLEN_W-1:0]    i_cfg_wdata,
    output ckx_pkg::t_qwr                 o_wr
);

    logic [ckx_pkg::KLEN_W-1:0]  r_kmer_len;
    logic [ckx_pkg::WORD_W-1:0]  r_fwd, n_fwd;
    logic [ckx_pkg::WORD_W-1:0]  r_rc, n_rc;
    logic [ckx_pkg::COUNT_W-1:0] r_count, n_count;
    logic [ckx_pkg::FLANK_W-1:0] r_drop, n_drop;

    logic [ckx_pkg::KLEN_W-1:0]  k_eff;
    logic [ckx_pkg::SHAMT_W-1:0] top_shamt;
    logic [ckx_pkg::WORD_W-1:0]  mask, fw_m, rc_m, fw_new, rc_new, top_shift;
    logic [ckx_pkg::FLANK_W-1:0] drop_new;
    logic [ckx_pkg::COUNT_W-1:0] diff;
    logic                        have_kmer;
    logic                        accept;

    always_comb begin
        if (r_kmer_len == '0) begin
            k_eff = 5'd1;
        end else if (r_kmer_len > ckx_pkg::MAX_K) begin
            k_eff = ckx_pkg::MAX_K;
        end else begin
            k_eff = r_kmer_len;
        end
        top_shamt = {k_eff - 5'd1, 1'b0};
        mask      = ~({ckx_pkg::WORD_W{1'b1}} << {k_eff, 1'b0});
        fw_m      = r_fwd & mask;
        rc_m      = r_rc & mask;
        have_kmer = (r_count >= ckx_pkg::COUNT_W'(k_eff));
        top_shift = fw_m >> top_shamt;
        drop_new  = have_kmer ? {1'b0, top_shift[1:0]} : r_drop;
        fw_new    = ((fw_m << 2) | {{(ckx_pkg::WORD_W-2){1'b0}}, i_base}) & mask;
        rc_new    = ((rc_m >> 2)
                    | ({{(ckx_pkg::WORD_W-2){1'b0}}, i_base ^ 2'b10} << top_shamt)) & mask;
        diff      = r_count - ckx_pkg::COUNT_W'(k_eff);
        accept    = i_push && !i_full;
    end

    // pending k-mer closed by this base, then the final one at the end of a read
    always_comb begin
        o_wr.valid0    = accept && have_kmer;
        o_wr.valid1    = accept && have_kmer && i_last_base;
        o_wr.req0.fwd  = fw_m;
        o_wr.req0.rc   = rc_m;
        o_wr.req0.prev = r_drop;
        o_wr.req0.next = {1'b0, i_base};
        o_wr.req0.pos  = diff[ckx_pkg::POS_W-1:0];
        o_wr.req0.last = 1'b0;
        o_wr.req1.fwd  = fw_new;
        o_wr.req1.rc   = rc_new;
        o_wr.req1.prev = drop_new;
        o_wr.req1.next = ckx_pkg::NONE_BASE;
        o_wr.req1.pos  = diff[ckx_pkg::POS_W-1:0] + 12'd1;
        o_wr.req1.last = 1'b1;
    end

    always_comb begin
        n_fwd   = r_fwd;
        n_rc    = r_rc;
        n_count = r_count;
        n_drop  = r_drop;
        if (accept) begin
            if (i_last_base) begin
                n_fwd   = '0;
                n_rc    = '0;
                n_count = '0;
                n_drop  = ckx_pkg::NONE_BASE;
            end else begin
                n_fwd   = fw_new;
                n_rc    = rc_new;
                n_drop  = drop_new;
                n_count = (r_count == ckx_pkg::COUNT_MAX) ? r_count : r_count + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_len <= ckx_pkg::KLEN_RESET;
            r_fwd      <= '0;
            r_rc       <= '0;
            r_count    <= '0;
            r_drop     <= ckx_pkg::NONE_BASE;
        end else begin
            if (i_cfg_we) begin
                r_kmer_len <= i_cfg_wdata;
            end
            r_fwd   <= n_fwd;
            r_rc    <= n_rc;
            r_count <= n_count;
            r_drop  <= n_drop;
        end
    end

endmodule

[hdl/ckx_queue.sv]
module ckx_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ckx_pkg::t_qwr  i_wr,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ckx_pkg::t_kreq o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ckx_pkg::t_kreq r_mem [DEPTH];
    logic [PW-1:0]  r_wptr, n_wptr, r_rptr, n_rptr, wptr1;
    logic [CW-1:0]  r_count, n_count, wr_num;
    logic           rd;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wptr1   = ptr_inc(r_wptr);
        wr_num  = CW'(i_wr.valid0) + CW'(i_wr.valid1);
        rd      = i_pop && !o_empty;
        n_count = r_count + wr_num - CW'(rd);
        n_rptr  = rd ? ptr_inc(r_rptr) : r_rptr;
        if (i_wr.valid0 && i_wr.valid1) begin
            n_wptr = ptr_inc(wptr1);
        end else if (i_wr.valid0 || i_wr.valid1) begin
            n_wptr = wptr1;
        end else begin
            n_wptr = r_wptr;
        end
    end

    // two free slots needed, as one base may close two k-mers
    assign o_full  = (r_count > CW'(DEPTH - 2));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_wr.valid0) begin
            r_mem[r_wptr] <= i_wr.req0;
        end
        if (i_wr.valid1) begin
            r_mem[i_wr.valid0 ? wptr1 : r_wptr] <= i_wr.req1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("request queue overflow");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.valid0 || i_wr.valid1) |-> !o_full)
        else $error("request written while queue full");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.valid1 |-> i_wr.valid0)
        else $error("second request without first");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> (r_wptr == r_rptr))
        else $error("pointers disagree on empty queue");

endmodule

[hdl/ckx_back.sv]
module ckx_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ckx_pkg::t_kreq                 i_head,
    input  logic                           i_head_valid,
    input  logic                           i_pop,
    output logic                           o_take,
    output logic                           o_empty,
    output logic [ckx_pkg::WORD_W-1:0]     o_canonical_kmer,
    output logic [ckx_pkg::FLANK_W-1:0]    o_prev_base,
    output logic [ckx_pkg::FLANK_W-1:0]    o_next_base,
    output logic                           o_from_reverse,
    output logic [ckx_pkg::POS_W-1:0]      o_kmer_pos,
    output logic                           o_last_kmer
);

    logic                        r_valid, n_valid;
    logic [ckx_pkg::WORD_W-1:0]  r_word, n_word;
    logic [ckx_pkg::FLANK_W-1:0] r_prev, n_prev, r_next, n_next;
    logic                        r_rev, n_rev, r_last, n_last;
    logic [ckx_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                        fwd_lt;

    function automatic logic [ckx_pkg::FLANK_W-1:0] comp_flank(
        input logic [ckx_pkg::FLANK_W-1:0] b
    );
        return (b[2]) ? ckx_pkg::NONE_BASE : {1'b0, b[1:0] ^ 2'b10};
    endfunction

    always_comb begin
        o_take  = i_head_valid && (!r_valid || i_pop);
        fwd_lt  = (i_head.fwd < i_head.rc);
        n_valid = o_take ? 1'b1 : (i_pop ? 1'b0 : r_valid);
        // ties go to the reverse strand
        if (fwd_lt) begin
            n_word = i_head.fwd;
            n_prev = i_head.prev;
            n_next = i_head.next;
            n_rev  = 1'b0;
        end else begin
            n_word = i_head.rc;
            n_prev = comp_flank(i_head.next);
            n_next = comp_flank(i_head.prev);
            n_rev  = 1'b1;
        end
        n_pos  = i_head.pos;
        n_last = i_head.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_word <= n_word;
            r_prev <= n_prev;
            r_next <= n_next;
            r_rev  <= n_rev;
            r_pos  <= n_pos;
            r_last <= n_last;
        end
    end

    assign o_empty          = !r_valid;
    assign o_canonical_kmer = r_word;
    assign o_prev_base      = r_prev;
    assign o_next_base      = r_next;
    assign o_from_reverse   = r_rev;
    assign o_kmer_pos       = r_pos;
    assign o_last_kmer      = r_last;

endmodule
